@@ sv/psss_pkg.sv @@
// ----------------------------------------------------------------------------
// psss_pkg
// Shared constants and types for the positive subarray sum search block.
// ----------------------------------------------------------------------------
`default_nettype none

package psss_pkg;

  localparam int unsigned MAX_LEN_DEF   = 1024;
  localparam int unsigned ELEM_BITS_DEF = 16;
  localparam int unsigned TARGET_W      = 32;
  localparam int unsigned SUM_W         = TARGET_W + 1;
  localparam int unsigned OUT_IDX_W     = 10;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_FINISH
  } psss_state_e;

endpackage

`default_nettype wire

@@ sv/psss_ifs.sv @@
// ----------------------------------------------------------------------------
// psss interfaces
// Element input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface psss_in_if #(
  parameter int unsigned ELEM_BITS = psss_pkg::ELEM_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] element_value;
  logic                 is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface psss_out_if;
  import psss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 match_found;
  logic [OUT_IDX_W-1:0] start_index;
  logic [OUT_IDX_W-1:0] end_index;
  logic                 overflow;

  modport source (output valid, output match_found, output start_index,
                  output end_index, output overflow, input ready);
  modport sink   (input valid, input match_found, input start_index,
                  input end_index, input overflow, output ready);
endinterface

`default_nettype wire

@@ sv/psss_window_ram.sv @@
// ----------------------------------------------------------------------------
// psss_window_ram
// Window element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psss_window_ram #(
  parameter int unsigned DEPTH  = psss_pkg::MAX_LEN_DEF,
  parameter int unsigned DATA_W = psss_pkg::ELEM_BITS_DEF,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/positive_subarray_sum_search.sv @@
// ----------------------------------------------------------------------------
// positive_subarray_sum_search
// Leftmost contiguous run of positive elements summing to a target value.
// ----------------------------------------------------------------------------
// Elements stream in one per transfer, numbered from 0 within an array; the
// transfer with is_last set yields one result transfer (match flag, start and
// end index, overflow). The block holds the current window in an on-chip
// store and keeps its running sum in one shared add/subtract unit driven by a
// small sequencer. While searching, each element dropped from the front of
// the window costs one registered store read and one subtract; every element
// is dropped at most once per array. Once a match is found or the array
// overruns MAX_LEN, further elements skip the search. A last element whose
// result meets a full output register waits there until the sink takes the
// earlier result. The user writes target_sum through cfg_we_i/cfg_wdata_i only
// while the block is idle, which the block does not enforce; it resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module positive_subarray_sum_search #(
  parameter int unsigned MAX_LEN   = psss_pkg::MAX_LEN_DEF,
  parameter int unsigned ELEM_BITS = psss_pkg::ELEM_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [psss_pkg::TARGET_W-1:0] cfg_wdata_i,
  psss_in_if.sink                            elem_i,
  psss_out_if.source                         result_o
);

  import psss_pkg::*;

  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LEN);

  psss_state_e state_q, state_d;

  logic [TARGET_W-1:0]  target_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     start_q;
  logic [CNT_W-1:0]     next_q;
  logic [IDX_W-1:0]     cur_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     found_start_q;
  logic [IDX_W-1:0]     found_end_q;
  logic                 ovf_q;
  logic                 last_q;

  logic                 out_valid_q;
  logic                 out_match_q;
  logic [OUT_IDX_W-1:0] out_start_q;
  logic [OUT_IDX_W-1:0] out_end_q;
  logic                 out_ovf_q;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 idx_ovf;
  logic                 search;
  logic                 too_big;
  logic                 in_window;
  logic                 pop_go;

  // sequencer outputs
  logic                 mem_we;
  logic                 mem_re;
  logic                 alu_add;
  logic                 alu_sub;
  logic                 set_found;
  logic                 emit;
  logic                 finish_go;

  logic [ELEM_BITS-1:0] rdata;
  logic [SUM_W-1:0]     alu_opnd;
  logic [SUM_W-1:0]     alu_res;

  assign in_xfer   = elem_i.valid && elem_i.ready;
  assign out_xfer  = result_o.valid && result_o.ready;
  assign idx_ovf   = (next_q >= LEN_LIMIT);
  assign search    = !idx_ovf && !found_q && !ovf_q;
  assign too_big   = (sum_q > SUM_W'(target_q));
  assign in_window = (start_q <= CNT_W'(cur_idx_q));
  assign pop_go    = too_big && in_window;

  assign elem_i.ready = (state_q == S_IDLE);

  psss_window_ram #(
    .DEPTH  (MAX_LEN),
    .DATA_W (ELEM_BITS)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (next_q[IDX_W-1:0]),
    .wdata_i (elem_i.element_value),
    .re_i    (mem_re),
    .raddr_i (start_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // shared add/subtract unit
  assign alu_opnd = alu_sub ? SUM_W'(rdata) : SUM_W'(elem_i.element_value);
  assign alu_res  = alu_sub ? (sum_q - alu_opnd) : (sum_q + alu_opnd);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = search ? S_CHECK : S_FINISH;
        end
      end
      S_CHECK: begin
        state_d = pop_go ? S_POP : S_FINISH;
      end
      S_POP: begin
        state_d = S_CHECK;
      end
      S_FINISH: begin
        if (finish_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    alu_add   = 1'b0;
    alu_sub   = 1'b0;
    set_found = 1'b0;
    emit      = 1'b0;
    finish_go = !last_q || !out_valid_q || result_o.ready;
    case (state_q)
      S_IDLE: begin
        mem_we  = in_xfer && search;
        alu_add = in_xfer && search;
      end
      S_CHECK: begin
        mem_re    = pop_go;
        set_found = !pop_go && in_window && (sum_q == SUM_W'(target_q));
      end
      S_POP: begin
        alu_sub = 1'b1;
      end
      S_FINISH: begin
        emit = last_q && finish_go;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q         <= '0;
      start_q       <= '0;
      next_q        <= '0;
      found_q       <= 1'b0;
      found_start_q <= '0;
      found_end_q   <= '0;
      ovf_q         <= 1'b0;
      last_q        <= 1'b0;
      cur_idx_q     <= '0;
    end else if (emit) begin
      sum_q         <= '0;
      start_q       <= '0;
      next_q        <= '0;
      found_q       <= 1'b0;
      found_start_q <= '0;
      found_end_q   <= '0;
      ovf_q         <= 1'b0;
    end else begin
      if (in_xfer) begin
        last_q    <= elem_i.is_last;
        cur_idx_q <= next_q[IDX_W-1:0];
        if (idx_ovf) begin
          ovf_q <= 1'b1;
        end else begin
          next_q <= next_q + CNT_W'(1);
        end
      end
      if (alu_add || alu_sub) begin
        sum_q <= alu_res;
      end
      if (alu_sub) begin
        start_q <= start_q + CNT_W'(1);
      end
      if (set_found) begin
        found_q       <= 1'b1;
        found_start_q <= start_q[IDX_W-1:0];
        found_end_q   <= cur_idx_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_match_q <= found_q && !ovf_q;
      out_start_q <= (found_q && !ovf_q) ? OUT_IDX_W'(found_start_q) : '0;
      out_end_q   <= (found_q && !ovf_q) ? OUT_IDX_W'(found_end_q) : '0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.match_found = out_match_q;
  assign result_o.start_index = out_start_q;
  assign result_o.end_index   = out_end_q;
  assign result_o.overflow    = out_ovf_q;

`ifndef ASSERT_OFF
  a_emit_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH && last_q))
    else $error("result raised outside finish of a last element");

  a_pop_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> $past(state_q == S_CHECK && mem_re))
    else $error("subtract without a preceding store read");

  a_start_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (start_q <= CNT_W'(cur_idx_q) + CNT_W'(1)))
    else $error("window start ran past the newest element");

  a_index_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= LEN_LIMIT)
    else $error("element counter beyond its limit");
`endif

endmodule

`default_nettype wire

@@ sim/subarray_match_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subarray_match_checker
// Watches the element and result channels of the subarray sum search block,
// keeps its own sliding window per array, and compares every result transfer
// field by field with the oldest predicted match report.
// ----------------------------------------------------------------------------

module subarray_match_checker #(
  parameter int unsigned MAX_LEN   = psss_pkg::MAX_LEN_DEF,
  parameter int unsigned ELEM_BITS = psss_pkg::ELEM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psss_pkg::TARGET_W-1:0] cfg_wdata_i,
  psss_in_if                            elem_i,
  psss_out_if                           result_i,
  output int                            failures_o,
  output int                            pending_o
);
  import psss_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] last_idx;
    logic                 overran;
  } match_report_t;

  logic [ELEM_BITS-1:0] window_elems [MAX_LEN];
  logic [SUM_W-1:0]     window_total;
  logic [TARGET_W-1:0]  goal;
  int unsigned          front;
  int unsigned          fill;
  int unsigned          hit_first;
  int unsigned          hit_last;
  bit                   hit;
  bit                   overran;
  match_report_t        expected_matches [$];

  initial begin
    failures_o = 0;
    pending_o  = 0;
  end

  function automatic void restart_array();
    window_total = '0;
    front        = 0;
    fill         = 0;
    hit          = 1'b0;
    hit_first    = 0;
    hit_last     = 0;
    overran      = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    failures_o++;
  endtask

  function automatic void window_absorb(input logic [ELEM_BITS-1:0] value,
                                        input logic last_flag);
    match_report_t r;
    if (fill >= MAX_LEN) begin
      overran = 1'b1;
    end else begin
      // searching stops once a match is held or the array has overrun
      if (!hit && !overran) begin
        window_elems[fill] = value;
        window_total += SUM_W'(value);
        while (window_total > {1'b0, goal} && front <= fill) begin
          window_total -= SUM_W'(window_elems[front]);
          front++;
        end
        if (front <= fill && window_total == {1'b0, goal}) begin
          hit       = 1'b1;
          hit_first = front;
          hit_last  = fill;
        end
      end
      fill++;
    end
    if (last_flag) begin
      r.found     = hit && !overran;
      r.first_idx = r.found ? OUT_IDX_W'(hit_first) : '0;
      r.last_idx  = r.found ? OUT_IDX_W'(hit_last) : '0;
      r.overran   = overran;
      expected_matches.push_back(r);
      restart_array();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    match_report_t want;
    if (!rst_ni) begin
      goal = TARGET_RESET;
      restart_array();
      expected_matches.delete();
    end else begin
      if (cfg_we_i) begin
        goal = cfg_wdata_i;
      end
      if (elem_i.valid && elem_i.ready) begin
        window_absorb(elem_i.element_value, elem_i.is_last);
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("result transfers waiting", 1, 0);
        end else begin
          want = expected_matches.pop_front();
          if (result_i.match_found !== want.found) begin
            report_mismatch("match_found", result_i.match_found, want.found);
          end
          if (result_i.start_index !== want.first_idx) begin
            report_mismatch("start_index", result_i.start_index, want.first_idx);
          end
          if (result_i.end_index !== want.last_idx) begin
            report_mismatch("end_index", result_i.end_index, want.last_idx);
          end
          if (result_i.overflow !== want.overran) begin
            report_mismatch("overflow", result_i.overflow, want.overran);
          end
        end
      end
    end
    pending_o = expected_matches.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the positive subarray sum search block: directed
// arrays for exact, missed, late and overrun matches, then random phases of
// planted runs and noise under several targets, with bursty input and a
// stalling result sink. Checking is done by subarray_match_checker.
// ----------------------------------------------------------------------------

module testbench;
  import psss_pkg::*;

  localparam int unsigned ELEM_W          = ELEM_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned PHASE_ITEMS     = 92;
  localparam int unsigned RANDOM_PHASES   = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [TARGET_W-1:0] cfg_wdata_i;

  int                  failures;
  int                  pending;
  int unsigned         burst_left;
  int unsigned         idle_cycles;
  bit                  hold_off_armed;
  bit                  hold_off_done;
  logic [ELEM_W-1:0]   elem_seq [$];

  psss_in_if #(.ELEM_BITS(ELEM_W)) elem_ch ();
  psss_out_if                      result_ch ();

  positive_subarray_sum_search #(
    .MAX_LEN   (MAX_LEN_DEF),
    .ELEM_BITS (ELEM_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_i      (elem_ch),
    .result_o    (result_ch)
  );

  subarray_match_checker #(
    .MAX_LEN   (MAX_LEN_DEF),
    .ELEM_BITS (ELEM_W)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_i      (elem_ch),
    .result_i    (result_ch),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (elem_ch.valid && elem_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink: random stall pattern, plus one long hold-off on request
  initial begin : result_sink
    logic        take;
    int unsigned mode;
    int unsigned run_len;
    result_ch.ready <= 1'b0;
    hold_off_done = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_armed && !hold_off_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(1, 30);
      repeat (run_len) begin
        case (mode)
          0: begin
            take = 1'b1;
          end
          1: begin
            take = $urandom_range(0, 1);
          end
          default: begin
            take = ($urandom_range(0, 3) == 0);
          end
        endcase
        result_ch.ready <= take;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_element(input logic [ELEM_W-1:0] value, input logic last_flag);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        elem_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= value;
    elem_ch.is_last       <= last_flag;
    do @(posedge clk_i); while (!elem_ch.ready);
  endtask

  task automatic send_array();
    foreach (elem_seq[i]) begin
      send_element(elem_seq[i], i == elem_seq.size() - 1);
    end
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] value);
    elem_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic fill_ones(input int unsigned count);
    elem_seq.delete();
    repeat (count) elem_seq.push_back(ELEM_W'(1));
  endtask

  function automatic logic [ELEM_W-1:0] random_elem(input int unsigned emax);
    // the odd zero element, outside the stated range
    if ($urandom_range(0, 39) == 0) begin
      return '0;
    end
    return ELEM_W'($urandom_range(1, emax));
  endfunction

  // a random prefix, a run that sums exactly to the goal, a random suffix;
  // a quarter of the arrays, and every one whose run would exceed 24, are plain noise
  function automatic void build_array(input int unsigned emax,
                                      input logic [TARGET_W-1:0] goal);
    longint unsigned run_len;
    longint unsigned remain;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned left;
    longint unsigned part;
    elem_seq.delete();
    run_len = (longint'(goal) + emax - 1) / emax + $urandom_range(0, 2);
    if (run_len > goal) begin
      run_len = goal;
    end
    if (goal == 0 || run_len > 24 || $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 20)) elem_seq.push_back(random_elem(emax));
    end else begin
      repeat ($urandom_range(0, 8)) elem_seq.push_back(random_elem(emax));
      remain = goal;
      for (longint unsigned k = 0; k < run_len; k++) begin
        left = run_len - 1 - k;
        lo   = (remain > left * emax) ? remain - left * emax : 1;
        hi   = (remain - left < emax) ? remain - left : emax;
        part = $urandom_range(int'(hi), int'(lo));
        elem_seq.push_back(ELEM_W'(part));
        remain -= part;
      end
      repeat ($urandom_range(0, 6)) elem_seq.push_back(random_elem(emax));
    end
  endfunction

  initial begin : stimulus
    int unsigned         phase_items;
    int unsigned         emax;
    logic [TARGET_W-1:0] phase_goal;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= '0;
    elem_ch.valid         <= 1'b0;
    elem_ch.element_value <= '0;
    elem_ch.is_last       <= 1'b0;
    burst_left     = 0;
    hold_off_armed = 1'b0;
    idle_cycles    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_target(TARGET_W'(1));
    elem_seq = '{ELEM_W'(1)};
    send_array();
    elem_seq = '{ELEM_W'(2), ELEM_W'(1)};
    send_array();
    elem_seq = '{ELEM_W'(65535)};
    send_array();

    write_target('1);
    elem_seq = '{ELEM_W'(65535), ELEM_W'(65535)};
    send_array();

    write_target(TARGET_W'(10));
    elem_seq = '{ELEM_W'(3), ELEM_W'(4), ELEM_W'(3), ELEM_W'(7)};
    send_array();
    elem_seq = '{ELEM_W'(4), ELEM_W'(4), ELEM_W'(4)};
    send_array();
    elem_seq = '{ELEM_W'(0), ELEM_W'(10)};
    send_array();
    elem_seq = '{ELEM_W'(9), ELEM_W'(2), ELEM_W'(8)};
    send_array();

    write_target('0);
    elem_seq = '{ELEM_W'(5), ELEM_W'(0)};
    send_array();
    elem_seq = '{ELEM_W'(7)};
    send_array();

    // match at the very last index, after draining the whole window
    write_target(TARGET_W'(65535));
    fill_ones(MAX_LEN_DEF - 1);
    elem_seq.push_back(ELEM_W'(65535));
    send_array();

    write_target(TARGET_W'(MAX_LEN_DEF));
    fill_ones(MAX_LEN_DEF);
    send_array();

    // early match, then the array runs past the store
    write_target(TARGET_W'(3));
    fill_ones(MAX_LEN_DEF + 6);
    send_array();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          emax       = 3;
          phase_goal = $urandom_range(1, 12);
        end
        1: begin
          emax       = 15;
          phase_goal = $urandom_range(1, 150);
        end
        2: begin
          emax       = 255;
          phase_goal = $urandom_range(1, 2000);
        end
        3: begin
          emax       = 65535;
          phase_goal = $urandom_range(65536, 500000);
        end
        4: begin
          emax       = 65535;
          phase_goal = $urandom() | 32'h8000_0000;
        end
        default: begin
          emax       = 40;
          phase_goal = $urandom_range(1, 300);
        end
      endcase
      write_target(phase_goal);
      if (p == 1) begin
        hold_off_armed = 1'b1;
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_array(emax, phase_goal);
        send_array();
        phase_items += elem_seq.size();
      end
    end

    elem_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/psss_pkg.sv
sv/psss_ifs.sv
sv/psss_window_ram.sv
sv/positive_subarray_sum_search.sv
sim/subarray_match_checker.sv
sim/testbench.sv
